FILE: hw/rtl/pfa_pkg.sv
// Types and constants for the arithmetic unit over the field of p = 2^255 - 19.
// Depends on nothing; every other file of the unit imports it.
package pfa_pkg;

    localparam logic [2:0] CMD_ADD    = 3'd0;
    localparam logic [2:0] CMD_SUB    = 3'd1;
    localparam logic [2:0] CMD_MUL    = 3'd2;
    localparam logic [2:0] CMD_SQR    = 3'd3;
    localparam logic [2:0] CMD_REDUCE = 3'd4;

    // The prime and four times the prime, the latter keeps a subtraction positive.
    localparam logic [255:0] PRIME  = (256'd1 << 255) - 256'd19;
    localparam logic [258:0] FOUR_P = (259'd1 << 257) - 259'd76;

    typedef struct packed {
        logic [2:0]  command;
        logic [63:0] a_limb0;
        logic [63:0] a_limb1;
        logic [63:0] a_limb2;
        logic [63:0] a_limb3;
        logic [63:0] b_limb0;
        logic [63:0] b_limb1;
        logic [63:0] b_limb2;
        logic [63:0] b_limb3;
    } cmd_t;

    typedef struct packed {
        logic [63:0] r_limb0;
        logic [63:0] r_limb1;
        logic [63:0] r_limb2;
        logic [62:0] r_limb3;
    } res_t;

endpackage

FILE: hw/rtl/prime_field_alu_p25519.sv
// Top level of the arithmetic unit over the field of p = 2^255 - 19.
// Depends on pfa_pkg for the transaction types, command codes and constants.
//
// The unit takes one transaction per cycle while cmd_stall is low: a command
// (add, subtract, multiply, square or reduce) and two 256-bit operands as four
// 64-bit limbs each, and returns one result per transaction, fully reduced into
// 0..p-1. Operands need not be reduced; any value up to 2^256-1 is accepted.
// Unused command codes give an all-zero result. Results leave in the order the
// transactions came in, whatever the command. Stage one forms the 64 partial
// products of 32 by 32 bits, stages two and three add them up column by column,
// stage four resolves the carries into the 512-bit product, stage five folds
// the upper half back with weight 38, stages six and seven fold the bits above
// 2^255 back with weight 19, and stage eight subtracts p once where needed into
// the output register. Add, subtract and reduce ride the same pipe so that order
// is kept. The whole pipe moves as one: cmd_stall is high exactly while a shown
// result is held by res_stall.
module prime_field_alu_p25519 (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  pfa_pkg::cmd_t cmd,
    output logic          res_valid,
    input  logic          res_stall,
    output pfa_pkg::res_t res
);
    import pfa_pkg::*;

    localparam int NW    = 8;   // 32-bit words per operand
    localparam int NCOL  = 16;  // 32-bit columns of the product
    localparam int NGRP  = 4;   // row groups summed in stage two
    localparam int DEPTH = 8;

    logic adv;
    logic [DEPTH-1:0] valid_reg, valid_next;

    // Stage one.
    logic [31:0]  aw [NW];
    logic [31:0]  mw [NW];
    logic [255:0] a_full, b_full;
    logic [258:0] lin1_next;
    logic [63:0]  pp1_reg [NW][NW];
    logic [258:0] lin1_reg;
    logic         mul1_reg, zero1_reg;

    // Stage two.
    logic [33:0]  grp2_next [NCOL][NGRP];
    logic [33:0]  grp2_reg  [NCOL][NGRP];
    logic [258:0] lin2_reg;
    logic         mul2_reg, zero2_reg;

    // Stage three.
    logic [35:0]  col3_next [NCOL];
    logic [35:0]  col3_reg  [NCOL];
    logic [258:0] lin3_reg;
    logic         mul3_reg, zero3_reg;

    // Stage four to eight.
    logic [543:0] v_even, v_odd;
    logic [511:0] x4_next, x4_reg;
    logic         zero4_reg;
    logic [261:0] t5_next, t5_reg;
    logic         zero5_reg;
    logic [255:0] f6_next, f6_reg;
    logic         zero6_reg;
    logic [254:0] f7_next, f7_reg;
    logic         zero7_reg;
    logic [256:0] diff8;
    logic [254:0] r8;
    res_t         res_reg, res_next;

    assign adv       = !(valid_reg[DEPTH-1] && res_stall);
    assign cmd_stall = !adv;
    assign res_valid = valid_reg[DEPTH-1];
    assign res       = res_reg;

    assign valid_next = {valid_reg[DEPTH-2:0], cmd_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= valid_next;
        end
    end

    // Stage one: partial products and the linear commands.
    assign a_full = {cmd.a_limb3, cmd.a_limb2, cmd.a_limb1, cmd.a_limb0};
    assign b_full = {cmd.b_limb3, cmd.b_limb2, cmd.b_limb1, cmd.b_limb0};

    always_comb
    begin
        for (int i = 0; i < NW; i++)
        begin
            aw[i] = a_full[32*i +: 32];
            mw[i] = (cmd.command == CMD_SQR) ? a_full[32*i +: 32] : b_full[32*i +: 32];
        end
        unique case (cmd.command)
            CMD_ADD:    lin1_next = {3'b0, a_full} + {3'b0, b_full};
            CMD_SUB:    lin1_next = {3'b0, a_full} + FOUR_P - {3'b0, b_full};
            CMD_REDUCE: lin1_next = {3'b0, a_full};
            default:    lin1_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < NW; i++)
            begin
                for (int j = 0; j < NW; j++)
                begin
                    pp1_reg[i][j] <= {32'b0, aw[i]} * {32'b0, mw[j]};
                end
            end
            lin1_reg  <= lin1_next;
            mul1_reg  <= (cmd.command == CMD_MUL) || (cmd.command == CMD_SQR);
            zero1_reg <= (cmd.command > CMD_REDUCE);
        end
    end

    // Stage two: for each column, the low and high halves from two rows at a time.
    always_comb
    begin
        for (int k = 0; k < NCOL; k++)
        begin
            for (int g = 0; g < NGRP; g++)
            begin
                grp2_next[k][g] = '0;
                for (int i = 2*g; i < 2*g + 2; i++)
                begin
                    if (k - i >= 0 && k - i < NW)
                    begin
                        grp2_next[k][g] = grp2_next[k][g] + {2'b0, pp1_reg[i][k-i][31:0]};
                    end
                    if (k - 1 - i >= 0 && k - 1 - i < NW)
                    begin
                        grp2_next[k][g] = grp2_next[k][g]
                                        + {2'b0, pp1_reg[i][k-1-i][63:32]};
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            grp2_reg  <= grp2_next;
            lin2_reg  <= lin1_reg;
            mul2_reg  <= mul1_reg;
            zero2_reg <= zero1_reg;
        end
    end

    // Stage three: column sums.
    always_comb
    begin
        for (int k = 0; k < NCOL; k++)
        begin
            col3_next[k] = {2'b0, grp2_reg[k][0]} + {2'b0, grp2_reg[k][1]}
                         + {2'b0, grp2_reg[k][2]} + {2'b0, grp2_reg[k][3]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            col3_reg  <= col3_next;
            lin3_reg  <= lin2_reg;
            mul3_reg  <= mul2_reg;
            zero3_reg <= zero2_reg;
        end
    end

    // Stage four: even and odd columns do not overlap among themselves,
    // so one add resolves every carry of the product.
    always_comb
    begin
        v_even = '0;
        v_odd  = '0;
        for (int m = 0; m < NCOL/2; m++)
        begin
            v_even[64*m +: 36]      = col3_reg[2*m];
            v_odd[64*m + 32 +: 36]  = col3_reg[2*m+1];
        end
        if (mul3_reg)
        begin
            x4_next = v_even[511:0] + v_odd[511:0];
        end
        else
        begin
            x4_next = {253'b0, lin3_reg};
        end
    end

    // Stage five: upper half folded back with weight 38 = 32 + 4 + 2.
    assign t5_next = {6'b0, x4_reg[255:0]} + {1'b0, x4_reg[511:256], 5'b0}
                   + {4'b0, x4_reg[511:256], 2'b0} + {5'b0, x4_reg[511:256], 1'b0};

    // Stages six and seven: bits at 2^255 and above folded back with weight 19.
    assign f6_next = {1'b0, t5_reg[254:0]} + {244'b0, 5'b0, t5_reg[261:255]} * 256'd19;
    assign f7_next = f6_reg[254:0] + (f6_reg[255] ? 255'd19 : 255'd0);

    // Stage eight: one conditional subtract of p gives the canonical value.
    always_comb
    begin
        diff8 = {2'b0, f7_reg} - {1'b0, PRIME};
        r8    = diff8[256] ? f7_reg : diff8[254:0];
        if (zero7_reg)
        begin
            r8 = '0;
        end
        res_next.r_limb0 = r8[63:0];
        res_next.r_limb1 = r8[127:64];
        res_next.r_limb2 = r8[191:128];
        res_next.r_limb3 = r8[254:192];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x4_reg    <= x4_next;
            zero4_reg <= zero3_reg;
            t5_reg    <= t5_next;
            zero5_reg <= zero4_reg;
            f6_reg    <= f6_next;
            zero6_reg <= zero5_reg;
            f7_reg    <= f7_next;
            zero7_reg <= zero6_reg;
            res_reg   <= res_next;
        end
    end

endmodule

FILE: hw/rtl/pfa_checker.sv
// Port checker for the field arithmetic unit, bound to its top level.
// Depends on pfa_pkg for the transaction types.
module pfa_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          cmd_valid,
    input logic          cmd_stall,
    input pfa_pkg::cmd_t cmd,
    input logic          res_valid,
    input logic          res_stall,
    input pfa_pkg::res_t res
);
    import pfa_pkg::*;

    // A stalled command stays offered and unchanged.
    a_cmd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_stall |=> cmd_valid && $stable(cmd))
        else $error("stalled command changed");

    // A held result stays shown and unchanged.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("held result changed");

    // The whole pipe stalls exactly when a shown result is held.
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall == (res_valid && res_stall))
        else $error("input stall does not follow output stall");

    // Every result is canonical, below p.
    a_canon: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.r_limb3 != 63'h7fffffffffffffff)
                   || (res.r_limb2 != 64'hffffffffffffffff)
                   || (res.r_limb1 != 64'hffffffffffffffff)
                   || (res.r_limb0 < 64'hffffffffffffffed))
        else $error("result not fully reduced");

endmodule

bind prime_field_alu_p25519 pfa_checker u_pfa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);

FILE: tb/sv/tb.sv
// Self-checking testbench for the arithmetic unit over the field of p = 2^255 - 19.
// Depends on pfa_pkg and prime_field_alu_p25519; it predicts each residue with wide
// integer arithmetic and compares every result transaction against it in order.
module tb;
    import pfa_pkg::*;

    // Holds the residues still owed by the unit and checks them in arrival order.
    class residue_board;
        res_t owed[$];
        int   errors;

        // Works out the canonical residue of one command transaction.
        function res_t field_result(cmd_t c);
            logic [511:0] a;
            logic [511:0] b;
            logic [511:0] p;
            logic [511:0] v;
            res_t r;
            a = {256'd0, c.a_limb3, c.a_limb2, c.a_limb1, c.a_limb0};
            b = {256'd0, c.b_limb3, c.b_limb2, c.b_limb1, c.b_limb0};
            p = {256'd0, PRIME};
            case (c.command)
                CMD_ADD:    v = (a + b) % p;
                // Adding a multiple of p keeps a difference below zero positive.
                CMD_SUB:    v = (a + (p << 2) - b) % p;
                CMD_MUL:    v = (a * b) % p;
                CMD_SQR:    v = (a * a) % p;
                CMD_REDUCE: v = a % p;
                default:    v = '0;
            endcase
            r.r_limb0 = v[63:0];
            r.r_limb1 = v[127:64];
            r.r_limb2 = v[191:128];
            r.r_limb3 = v[254:192];
            return r;
        endfunction

        function void note_command(cmd_t c);
            owed.push_back(field_result(c));
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (owed.size() == 0)
            begin
                report_mismatch("result arrived with nothing outstanding");
                return;
            end
            want = owed.pop_front();
            if (got.r_limb0 !== want.r_limb0)
                report_mismatch($sformatf("r_limb0 %h, expected %h", got.r_limb0, want.r_limb0));
            if (got.r_limb1 !== want.r_limb1)
                report_mismatch($sformatf("r_limb1 %h, expected %h", got.r_limb1, want.r_limb1));
            if (got.r_limb2 !== want.r_limb2)
                report_mismatch($sformatf("r_limb2 %h, expected %h", got.r_limb2, want.r_limb2));
            if (got.r_limb3 !== want.r_limb3)
                report_mismatch($sformatf("r_limb3 %h, expected %h", got.r_limb3, want.r_limb3));
        endfunction

        function void report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cmd_valid;
    logic cmd_stall;
    cmd_t cmd;
    logic res_valid;
    logic res_stall;
    res_t res;

    residue_board board;
    bit           sending_done;
    bit           hold_off;

    prime_field_alu_p25519 uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Limb values lean towards the edges, where carries and the fold bite hardest.
    function automatic logic [63:0] pick_limb();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return 64'hffff_ffff_ffff_ffed;
            3:       return 64'h7fff_ffff_ffff_ffff;
            4:       return 64'h8000_0000_0000_0000;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic cmd_t random_command();
        cmd_t c;
        // Codes five to seven are unused and must give zero; give them a small share.
        c.command = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                                 : 3'($urandom_range(0, 4));
        c.a_limb0 = pick_limb();
        c.a_limb1 = pick_limb();
        c.a_limb2 = pick_limb();
        c.a_limb3 = pick_limb();
        c.b_limb0 = pick_limb();
        c.b_limb1 = pick_limb();
        c.b_limb2 = pick_limb();
        c.b_limb3 = pick_limb();
        return c;
    endfunction

    // Offers one transaction and holds it steady until the unit takes it.
    // Valid drops only for a gap, so back-to-back transactions keep it high.
    task automatic send_command(cmd_t c);
        int gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        board.note_command(c);
    endtask

    function automatic cmd_t make_command(logic [2:0] code, logic [255:0] a, logic [255:0] b);
        cmd_t c;
        c.command = code;
        {c.a_limb3, c.a_limb2, c.a_limb1, c.a_limb0} = a;
        {c.b_limb3, c.b_limb2, c.b_limb1, c.b_limb0} = b;
        return c;
    endfunction

    // Stimulus: directed edge cases first, then a long random stream.
    initial
    begin
        logic [255:0] all_ones;
        logic [255:0] prime_v;
        board        = new();
        all_ones     = '1;
        prime_v      = PRIME;
        sending_done = 1'b0;
        rst_n        = 1'b0;
        cmd_valid    = 1'b0;
        cmd          = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_command(make_command(CMD_ADD, 256'd0, 256'd0));
        send_command(make_command(CMD_ADD, all_ones, all_ones));
        send_command(make_command(CMD_ADD, prime_v - 1, 256'd1));
        send_command(make_command(CMD_SUB, 256'd0, all_ones));
        send_command(make_command(CMD_SUB, 256'd5, 256'd7));
        send_command(make_command(CMD_SUB, all_ones, 256'd0));
        send_command(make_command(CMD_SUB, prime_v, prime_v));
        send_command(make_command(CMD_MUL, all_ones, all_ones));
        send_command(make_command(CMD_MUL, prime_v - 1, prime_v - 1));
        send_command(make_command(CMD_MUL, 256'd0, all_ones));
        send_command(make_command(CMD_MUL, prime_v, 256'd3));
        send_command(make_command(CMD_SQR, all_ones, 256'd0));
        send_command(make_command(CMD_SQR, prime_v + 1, all_ones));
        send_command(make_command(CMD_REDUCE, prime_v, all_ones));
        send_command(make_command(CMD_REDUCE, all_ones, 256'd0));
        send_command(make_command(CMD_REDUCE, prime_v - 1, 256'd0));
        send_command(make_command(CMD_REDUCE, prime_v + 18, 256'd0));
        send_command(make_command(3'd5, all_ones, all_ones));
        send_command(make_command(3'd6, prime_v, 256'd1));
        send_command(make_command(3'd7, all_ones, all_ones));

        repeat (750)
            send_command(random_command());
        cmd_valid <= 1'b0;
        sending_done = 1'b1;
    end

    // Receiver: random stalls, plus one long hold-off that backs the pipe up.
    initial
    begin
        int gap;
        res_stall = 1'b1;
        hold_off  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
                res_stall <= 1'b1;
            else
            begin
                gap = pick_gap();
                res_stall <= (gap != 0);
                if (gap != 0)
                begin
                    repeat (gap) @(posedge clk);
                    res_stall <= 1'b0;
                end
            end
        end
    end

    // The long hold-off runs in its own process, counted in cycles.
    initial
    begin
        @(posedge rst_n);
        repeat (300) @(posedge clk);
        hold_off = 1'b1;
        repeat (60) @(posedge clk);
        hold_off = 1'b0;
    end

    // Checks every result transaction the unit hands over.
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
            board.check_result(res);
    end

    // End of run: wait for the unit to drain, then allow its latency once more.
    initial
    begin
        @(posedge rst_n);
        wait (sending_done);
        while (board.owed.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (board.errors == 0 && board.owed.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Guard against a hung unit; the slowest correct run is far shorter than this.
    initial
    begin
        #1000000;
        $display("Test completed with failures");
        $finish;
    end
endmodule
